// File: hdl/bssa_pkg.sv
// shared constants and field widths for the slab slot allocator
`timescale 1ns / 1ps

package bssa_pkg;

	// default geometry of the bucket chain
	localparam int MAX_BUCKETS_DEF      = 8;
	localparam int SLOTS_PER_BUCKET_DEF = 32;

	// fixed widths of the request and response fields
	localparam int CMD_W    = 1;
	localparam int BUCKET_W = 3;
	localparam int SLOT_W   = 5;

	// request codes
	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

endpackage

// File: hdl/bitmap_slab_slot_allocator.sv
// slab slot allocator: chain of buckets with a used bitmap per bucket
//
//  channel | direction | handshake             | fields
//  --------+-----------+-----------------------+--------------------------------
//  req     | in        | req_valid, req_stall  | cmd, free_bucket, free_slot
//  rsp     | out       | rsp_valid, rsp_stall  | ok, got_bucket, got_slot
//
// one request per cycle sustained while rsp_stall is low; each transfer passes
// through the request register and then the response register to its response.
// the bitmaps live in flip-flops, so the priority search over every bucket
// finishes between those two registers and the state updates at the same edge.
// reset clears all bitmaps and leaves bucket 0 active; no clearing pass.
// a stalled response holds the pipe; a new request still enters when the
// request register drains into the response register in the same cycle.
`timescale 1ns / 1ps

module bitmap_slab_slot_allocator #(
	parameter int MAX_BUCKETS      = bssa_pkg::MAX_BUCKETS_DEF,
	parameter int SLOTS_PER_BUCKET = bssa_pkg::SLOTS_PER_BUCKET_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [bssa_pkg::CMD_W-1:0]    cmd,
	input  logic [bssa_pkg::BUCKET_W-1:0] free_bucket,
	input  logic [bssa_pkg::SLOT_W-1:0]   free_slot,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic                         ok,
	output logic [bssa_pkg::BUCKET_W-1:0] got_bucket,
	output logic [bssa_pkg::SLOT_W-1:0]   got_slot
);
	import bssa_pkg::*;

	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int SW = $clog2(SLOTS_PER_BUCKET);
	localparam int AW = $clog2(MAX_BUCKETS + 1);

	// request register
	logic                valid_s1;
	logic [CMD_W-1:0]    cmd_s1;
	logic [BUCKET_W-1:0] free_bucket_s1;
	logic [SLOT_W-1:0]   free_slot_s1;

	// allocator state
	logic [SLOTS_PER_BUCKET-1:0] used_q [MAX_BUCKETS];
	logic [AW-1:0]               active_q;

	// response register
	logic                valid_s2;
	logic                ok_s2;
	logic [BUCKET_W-1:0] got_bucket_s2;
	logic [SLOT_W-1:0]   got_slot_s2;

	logic advance;
	logic take_req;
	logic take_s1;

	// search results
	logic [MAX_BUCKETS-1:0] has_free;
	logic [SW-1:0]          top_slot [MAX_BUCKETS];
	logic                   any_found;
	logic [BW-1:0]          found_b;

	// next state and response
	logic [SLOTS_PER_BUCKET-1:0] used_d [MAX_BUCKETS];
	logic [AW-1:0]               active_d;
	logic                        ok_d;
	logic [BUCKET_W-1:0]         got_bucket_d;
	logic [SLOT_W-1:0]           got_slot_d;
	logic                        free_hit;
	logic [BW-1:0]               fb_idx;
	logic [SW-1:0]               fs_idx;

	// handshake: the response register frees up when empty or taken
	assign advance   = ~valid_s2 | ~rsp_stall;
	assign req_stall = valid_s1 & ~advance;
	assign take_req  = req_valid & ~req_stall;
	assign take_s1   = valid_s1 & advance;

	// per bucket: is it active with a free slot, and its highest free slot
	always_comb begin
		for (int b = 0; b < MAX_BUCKETS; b++) begin
			has_free[b] = 1'b0;
			top_slot[b] = '0;
			for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
				if (!used_q[b][s]) begin
					has_free[b] = (b < int'(active_q));
					top_slot[b] = SW'(s);
				end
			end
		end
	end

	// lowest-numbered bucket with room wins
	always_comb begin
		any_found = 1'b0;
		found_b   = '0;
		for (int b = MAX_BUCKETS - 1; b >= 0; b--) begin
			if (has_free[b]) begin
				any_found = 1'b1;
				found_b   = BW'(b);
			end
		end
	end

	// free request decode
	assign fb_idx   = BW'(free_bucket_s1);
	assign fs_idx   = SW'(free_slot_s1);
	assign free_hit = (int'(free_bucket_s1) < int'(active_q)) &&
	                  (int'(free_bucket_s1) < MAX_BUCKETS) &&
	                  (int'(free_slot_s1) < SLOTS_PER_BUCKET);

	// state update and response for the request in the input register
	always_comb begin
		used_d       = used_q;
		active_d     = active_q;
		ok_d         = 1'b0;
		got_bucket_d = '0;
		got_slot_d   = '0;
		if (cmd_s1 == CMD_FREE) begin
			if (free_hit) begin
				used_d[fb_idx][fs_idx] = 1'b0;
				ok_d                   = 1'b1;
			end
		end else if (any_found) begin
			used_d[found_b][top_slot[found_b]] = 1'b1;
			ok_d         = 1'b1;
			got_bucket_d = BUCKET_W'(found_b);
			got_slot_d   = SLOT_W'(top_slot[found_b]);
		end else if (int'(active_q) < MAX_BUCKETS) begin
			// every active bucket is full: open the next one, take its top slot
			used_d[BW'(active_q)][SLOTS_PER_BUCKET-1] = 1'b1;
			active_d     = active_q + AW'(1);
			ok_d         = 1'b1;
			got_bucket_d = BUCKET_W'(active_q);
			got_slot_d   = SLOT_W'(SLOTS_PER_BUCKET - 1);
		end
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			active_q <= AW'(1);
			for (int b = 0; b < MAX_BUCKETS; b++) begin
				used_q[b] <= '0;
			end
		end else begin
			if (take_req) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (take_s1) begin
				used_q   <= used_d;
				active_q <= active_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_req) begin
			cmd_s1         <= cmd;
			free_bucket_s1 <= free_bucket;
			free_slot_s1   <= free_slot;
		end
		if (take_s1) begin
			ok_s2         <= ok_d;
			got_bucket_s2 <= got_bucket_d;
			got_slot_s2   <= got_slot_d;
		end
	end

	assign rsp_valid  = valid_s2;
	assign ok         = ok_s2;
	assign got_bucket = got_bucket_s2;
	assign got_slot   = got_slot_s2;

endmodule

// File: tb/bitmap_slab_slot_allocator_tb.sv
// self-checking testbench for the bitmap slab slot allocator
`timescale 1ns / 1ps

module bitmap_slab_slot_allocator_tb;
	import bssa_pkg::*;

	localparam int NUM_BUCKETS   = MAX_BUCKETS_DEF;
	localparam int NUM_SLOTS     = SLOTS_PER_BUCKET_DEF;
	localparam int RANDOM_ITEMS  = 1450;
	localparam int STALL_LIMIT   = 5000;
	localparam int DRAIN_CYCLES  = 6;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic                ok;
		logic [BUCKET_W-1:0] bucket;
		logic [SLOT_W-1:0]   slot;
	} slot_grant_t;

	// tracks the allocator's bitmaps and holds the grants still owed
	class slab_scoreboard;
		bit [NUM_SLOTS-1:0]   used_map [NUM_BUCKETS];
		int                   live_buckets = 1;
		slot_grant_t          owed_grants[$];
		int                   errors = 0;

		function void flag_error(string msg);
			if (errors < REPORT_LIMIT)
				$display("%0t: %s", $realtime, msg);
			errors++;
		endfunction

		function int pending();
			return owed_grants.size();
		endfunction

		// work out the grant an accepted request earns and update the bitmaps
		function void note_request(logic [CMD_W-1:0] op, logic [BUCKET_W-1:0] fb,
				logic [SLOT_W-1:0] fs);
			slot_grant_t g;
			bit          found;
			g = '0;
			found = 1'b0;
			if (op == CMD_FREE) begin
				if (int'(fb) < live_buckets && int'(fs) < NUM_SLOTS) begin
					used_map[fb][fs] = 1'b0;
					g.ok = 1'b1;
				end
			end else begin
				// highest free slot of the lowest bucket with room
				for (int b = 0; b < live_buckets; b++) begin
					if (!found && used_map[b] != '1) begin
						for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
							if (!found && !used_map[b][s]) begin
								found = 1'b1;
								used_map[b][s] = 1'b1;
								g.ok = 1'b1;
								g.bucket = b[BUCKET_W-1:0];
								g.slot = s[SLOT_W-1:0];
							end
						end
					end
				end
				// all live buckets full: bring up the next one, top slot
				if (!found && live_buckets < NUM_BUCKETS) begin
					used_map[live_buckets][NUM_SLOTS-1] = 1'b1;
					g.ok = 1'b1;
					g.bucket = live_buckets[BUCKET_W-1:0];
					g.slot = SLOT_W'(NUM_SLOTS - 1);
					live_buckets++;
				end
			end
			owed_grants.push_back(g);
		endfunction

		// compare a response transfer with the oldest owed grant
		function void check_response(slot_grant_t got);
			slot_grant_t want;
			if (owed_grants.size() == 0) begin
				flag_error($sformatf(
					"response with nothing owed: ok=%0d bucket=%0d slot=%0d",
					got.ok, got.bucket, got.slot));
				return;
			end
			want = owed_grants.pop_front();
			if (got.ok !== want.ok || got.bucket !== want.bucket || got.slot !== want.slot)
				flag_error($sformatf(
					"mismatch: want ok=%0d bucket=%0d slot=%0d, got ok=%0d bucket=%0d slot=%0d",
					want.ok, want.bucket, want.slot, got.ok, got.bucket, got.slot));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [CMD_W-1:0]    cmd = CMD_ALLOC;
	logic [BUCKET_W-1:0] free_bucket = '0;
	logic [SLOT_W-1:0]   free_slot = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic                ok;
	logic [BUCKET_W-1:0] got_bucket;
	logic [SLOT_W-1:0]   got_slot;

	slab_scoreboard sb = new;
	int  sent_items = 0;
	bit  req_quiet = 1'b0;
	bit  rsp_quiet = 1'b0;
	int  rsp_hold = 0;
	int  quiet_cycles = 0;

	bitmap_slab_slot_allocator uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.cmd         (cmd),
		.free_bucket (free_bucket),
		.free_slot   (free_slot),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.ok          (ok),
		.got_bucket  (got_bucket),
		.got_slot    (got_slot)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// response side: random stalls, changed on the falling edge
	always @(negedge clk) begin
		if (rsp_hold > 0) begin
			rsp_hold <= rsp_hold - 1;
		end else begin
			rsp_hold <= pick_gap(rsp_quiet);
		end
		rsp_stall <= (rsp_hold > 0);
	end

	// check each response transfer
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response('{ok, got_bucket, got_slot});
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// present one request and hold it until the transfer
	task automatic send_request(logic [CMD_W-1:0] op, logic [BUCKET_W-1:0] fb,
			logic [SLOT_W-1:0] fs);
		int gap;
		@(negedge clk);
		req_valid <= 1'b1;
		cmd <= op;
		free_bucket <= fb;
		free_slot <= fs;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(op, fb, fs);
		sent_items++;
		// idle cycles before the next request
		gap = pick_gap(req_quiet);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// allocate with junk in the ignored fields
	task automatic send_alloc();
		send_request(CMD_ALLOC, BUCKET_W'($urandom), SLOT_W'($urandom));
	endtask

	// free a slot that is most likely held, in a live bucket
	task automatic send_held_free();
		int b;
		int s;
		int pick;
		b = $urandom_range(0, sb.live_buckets - 1);
		pick = $urandom_range(0, NUM_SLOTS - 1);
		s = pick;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (sb.used_map[b][(pick + k) % NUM_SLOTS] && s == pick && !sb.used_map[b][pick])
				s = (pick + k) % NUM_SLOTS;
		end
		send_request(CMD_FREE, b[BUCKET_W-1:0], s[SLOT_W-1:0]);
	endtask

	// hold the sender until every owed grant has come back
	task automatic wait_for_drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int phase;
		int run;
		int r;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: free slot, inactive buckets, field extremes, reuse of freed slots
		send_request(CMD_FREE, 3'd0, 5'd31);
		send_request(CMD_FREE, 3'd7, 5'd0);
		send_request(CMD_FREE, 3'd1, 5'd31);
		send_request(CMD_FREE, 3'd7, 5'd31);
		send_request(CMD_ALLOC, 3'd0, 5'd0);
		send_request(CMD_ALLOC, 3'd0, 5'd0);
		send_request(CMD_ALLOC, 3'd7, 5'd31);
		send_request(CMD_FREE, 3'd0, 5'd31);
		send_request(CMD_ALLOC, 3'd5, 5'd10);
		send_request(CMD_FREE, 3'd0, 5'd0);
		send_request(CMD_FREE, 3'd0, 5'd30);
		send_request(CMD_ALLOC, 3'd2, 5'd21);
		send_request(CMD_FREE, 3'd0, 5'd31);
		wait_for_drain();

		// random phases; the first one fills every bucket and runs past the end
		phase = 0;
		while (sent_items < RANDOM_ITEMS) begin
			req_quiet = ($urandom_range(0, 3) == 0);
			rsp_quiet = ($urandom_range(0, 3) == 0);
			r = (phase == 0) ? 0 : $urandom_range(0, 9);
			if (r < 2) begin
				// allocation burst, long enough at first to exhaust the chain
				run = (phase == 0) ? $urandom_range(270, 300) : $urandom_range(10, 80);
				repeat (run) send_alloc();
			end else if (r < 8) begin
				// churn: frees of held slots, allocations and some noise
				run = $urandom_range(30, 120);
				repeat (run) begin
					r = $urandom_range(0, 99);
					if (r < 45)
						send_held_free();
					else if (r < 88)
						send_alloc();
					else
						send_request(CMD_FREE, BUCKET_W'($urandom), SLOT_W'($urandom));
				end
			end else begin
				// release run: free many held slots so buckets open up again
				run = $urandom_range(20, 90);
				repeat (run) send_held_free();
			end
			if ($urandom_range(0, 2) == 0)
				wait_for_drain();
			phase++;
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.flag_error($sformatf("%0d grants never returned", sb.pending()));
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
hdl/bssa_pkg.sv
hdl/bitmap_slab_slot_allocator.sv
tb/bitmap_slab_slot_allocator_tb.sv
